// File: rtl/sgip_pkg.sv
// ----------------------------------------------------------------------------
// sgip_pkg
// Shared widths, payload types and the final placement function for the
// segment intersection point unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sgip_pkg;

  // input coordinate and fixed-point format
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 32;

  // derived widths
  localparam int DW   = COORD_BITS + 1;           // coordinate differences
  localparam int PW   = 2 * DW;                   // 2x2 products
  localparam int SW   = PW + 1;                   // sums of products, divisor
  localparam int MW   = COORD_BITS;               // magnitude of a difference
  localparam int QW   = COORD_BITS + FRAC_BITS;   // quotient bits
  localparam int NW   = SW + MW;                  // dividend before scaling
  localparam int WIDE = 64;                       // placement arithmetic

  // per-item flags and base point that ride alongside the divider
  typedef struct packed {
    logic                         hit;
    logic                         col;
    logic                         deg;
    logic                         neg_x;
    logic                         neg_y;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
  } side_t;

  // operands handed from the front end to the divider
  typedef struct packed {
    logic [SW-1:0] cm;
    logic [SW-1:0] den;
    logic [MW-1:0] mag_x;
    logic [MW-1:0] mag_y;
    side_t         side;
  } opnd_t;

  // rounded quotients leaving the divider
  typedef struct packed {
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    side_t         side;
  } quot_t;

  // base point in fixed point plus or minus the rounded offset, wrapped
  function automatic logic [OUT_BITS-1:0] place(input logic signed [COORD_BITS-1:0] base,
                                                input logic [QW-1:0] q,
                                                input logic neg);
    logic signed [WIDE-1:0] b;
    logic signed [WIDE-1:0] qq;
    logic signed [WIDE-1:0] s;
    b  = WIDE'(base) <<< FRAC_BITS;
    qq = WIDE'(q);
    s  = neg ? (b - qq) : (b + qq);
    return s[OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/sgip_front.sv
// ----------------------------------------------------------------------------
// sgip_front
// Six-stage front end: differences, products, determinants, sign
// normalisation, range tests and divider operand selection.
// ----------------------------------------------------------------------------
`default_nettype none

module sgip_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] a_x,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] a_y,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] b_x,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] b_y,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] c_x,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] c_y,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] e_x,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] e_y,
  output logic                                   dn_valid,
  input  logic                                   dn_ready,
  output sgip_pkg::opnd_t                        dn_opnd
);

  localparam int DW = sgip_pkg::DW;
  localparam int PW = sgip_pkg::PW;
  localparam int SW = sgip_pkg::SW;
  localparam int MW = sgip_pkg::MW;
  localparam int NS = 6;

  // values carried unchanged down the front end
  typedef struct packed {
    logic [MW-1:0]                          mag_x;
    logic [MW-1:0]                          mag_y;
    logic                                   neg_x;
    logic                                   neg_y;
    logic                                   dz;
    logic signed [sgip_pkg::COORD_BITS-1:0] ax;
    logic signed [sgip_pkg::COORD_BITS-1:0] ay;
  } carry_t;

  logic [NS-1:0] v_r;
  wire  [NS-1:0] en;

  // stage 1
  logic signed [DW-1:0] dx1_r, dy1_r, ex1_r, ey1_r, rx1_r, ry1_r, sx1_r, sy1_r;
  logic signed [sgip_pkg::COORD_BITS-1:0] ax1_r, ay1_r;
  // stage 2
  logic signed [PW-1:0] pde2_r, ped2_r, pre2_r, per2_r, pdr2_r, prd2_r;
  logic signed [PW-1:0] pdd2_r, pyy2_r, pdx2_r, pdy2_r, psx2_r, psy2_r;
  carry_t car2_r, car2_nxt;
  logic signed [DW-1:0] ndx, ndy;
  // stage 3
  logic signed [SW-1:0] det3_r, nu3_r, nv3_r, len3_r, p03_r, p13_r;
  carry_t car3_r;
  // stage 4
  logic signed [SW-1:0] det4_r, nu4_r, nv4_r, len4_r, lo4_r, hi4_r;
  logic par4_r;
  carry_t car4_r;
  // stage 5
  logic signed [SW-1:0] det5_r, nu5_r, len5_r, loc5_r, hic5_r;
  logic hnp5_r, col5_r, deg5_r;
  carry_t car5_r;
  // stage 6
  sgip_pkg::opnd_t opnd6_r, opnd6_nxt;
  logic signed [SW-1:0] sum5;
  logic ovl5;

  // ready ripples back through empty stages
  assign en[NS-1] = !v_r[NS-1] || dn_ready;
  genvar g;
  generate
    for (g = 0; g < NS - 1; g++) begin : g_en
      assign en[g] = !v_r[g] || en[g+1];
    end
  endgenerate

  assign up_ready = en[0];
  assign dn_valid = v_r[NS-1];
  assign dn_opnd  = opnd6_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // magnitudes and signs of the first segment direction
  always_comb begin
    ndx            = -dx1_r;
    ndy            = -dy1_r;
    car2_nxt.mag_x = dx1_r[DW-1] ? ndx[MW-1:0] : dx1_r[MW-1:0];
    car2_nxt.mag_y = dy1_r[DW-1] ? ndy[MW-1:0] : dy1_r[MW-1:0];
    car2_nxt.neg_x = dx1_r[DW-1];
    car2_nxt.neg_y = dy1_r[DW-1];
    car2_nxt.dz    = (dx1_r == '0) && (dy1_r == '0);
    car2_nxt.ax    = ax1_r;
    car2_nxt.ay    = ay1_r;
  end

  // overlap test and operand choice
  always_comb begin
    ovl5                = loc5_r <= hic5_r;
    sum5                = loc5_r + hic5_r;
    opnd6_nxt.cm        = hnp5_r ? nu5_r : sum5;
    opnd6_nxt.den       = hnp5_r ? det5_r : (len5_r <<< 1);
    opnd6_nxt.mag_x     = car5_r.mag_x;
    opnd6_nxt.mag_y     = car5_r.mag_y;
    opnd6_nxt.side.hit  = hnp5_r || (col5_r && ovl5);
    opnd6_nxt.side.col  = col5_r;
    opnd6_nxt.side.deg  = deg5_r;
    opnd6_nxt.side.neg_x = car5_r.neg_x;
    opnd6_nxt.side.neg_y = car5_r.neg_y;
    opnd6_nxt.side.ax   = car5_r.ax;
    opnd6_nxt.side.ay   = car5_r.ay;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // differences
    if (en[0]) begin
      dx1_r <= DW'(b_x) - DW'(a_x);
      dy1_r <= DW'(b_y) - DW'(a_y);
      ex1_r <= DW'(c_x) - DW'(e_x);
      ey1_r <= DW'(c_y) - DW'(e_y);
      rx1_r <= DW'(c_x) - DW'(a_x);
      ry1_r <= DW'(c_y) - DW'(a_y);
      sx1_r <= DW'(e_x) - DW'(a_x);
      sy1_r <= DW'(e_y) - DW'(a_y);
      ax1_r <= a_x;
      ay1_r <= a_y;
    end
    // products
    if (en[1]) begin
      pde2_r <= dx1_r * ey1_r;
      ped2_r <= ex1_r * dy1_r;
      pre2_r <= rx1_r * ey1_r;
      per2_r <= ex1_r * ry1_r;
      pdr2_r <= dx1_r * ry1_r;
      prd2_r <= rx1_r * dy1_r;
      pdd2_r <= dx1_r * dx1_r;
      pyy2_r <= dy1_r * dy1_r;
      pdx2_r <= dx1_r * rx1_r;
      pdy2_r <= dy1_r * ry1_r;
      psx2_r <= dx1_r * sx1_r;
      psy2_r <= dy1_r * sy1_r;
      car2_r <= car2_nxt;
    end
    // determinant, numerators, projections
    if (en[2]) begin
      det3_r <= SW'(pde2_r) - SW'(ped2_r);
      nu3_r  <= SW'(pre2_r) - SW'(per2_r);
      nv3_r  <= SW'(pdr2_r) - SW'(prd2_r);
      len3_r <= SW'(pdd2_r) + SW'(pyy2_r);
      p03_r  <= SW'(pdx2_r) + SW'(pdy2_r);
      p13_r  <= SW'(psx2_r) + SW'(psy2_r);
      car3_r <= car2_r;
    end
    // make the determinant positive, order the projections
    if (en[3]) begin
      det4_r <= det3_r[SW-1] ? -det3_r : det3_r;
      nu4_r  <= det3_r[SW-1] ? -nu3_r : nu3_r;
      nv4_r  <= det3_r[SW-1] ? -nv3_r : nv3_r;
      len4_r <= len3_r;
      lo4_r  <= (p03_r < p13_r) ? p03_r : p13_r;
      hi4_r  <= (p03_r < p13_r) ? p13_r : p03_r;
      par4_r <= det3_r == '0;
      car4_r <= car3_r;
    end
    // parameter range test, collinear clamp
    if (en[4]) begin
      hnp5_r <= !par4_r && !nu4_r[SW-1] && (nu4_r <= det4_r) &&
                !nv4_r[SW-1] && (nv4_r <= det4_r);
      col5_r <= par4_r && !car4_r.dz && (nv4_r == '0);
      deg5_r <= par4_r && car4_r.dz;
      loc5_r <= lo4_r[SW-1] ? '0 : lo4_r;
      hic5_r <= (hi4_r > len4_r) ? len4_r : hi4_r;
      det5_r <= det4_r;
      nu5_r  <= nu4_r;
      len5_r <= len4_r;
      car5_r <= car4_r;
    end
    if (en[5]) begin
      opnd6_r <= opnd6_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sgip_div.sv
// ----------------------------------------------------------------------------
// sgip_div
// Two-lane pipelined restoring divider with a shared divisor: one multiply
// stage, one quotient bit per stage, then round to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module sgip_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  sgip_pkg::opnd_t up_opnd,
  output logic            dn_valid,
  input  logic            dn_ready,
  output sgip_pkg::quot_t dn_quot
);

  localparam int SW = sgip_pkg::SW;
  localparam int QW = sgip_pkg::QW;
  localparam int NW = sgip_pkg::NW;
  localparam int CB = sgip_pkg::COORD_BITS;
  localparam int FB = sgip_pkg::FRAC_BITS;
  localparam int NS = QW + 2;

  logic [NS-1:0] v_r;
  wire  [NS-1:0] en;

  logic [SW-1:0]   rem_r  [0:QW][0:1];
  logic [QW-1:0]   low_r  [0:QW][0:1];
  logic [QW-1:0]   q_r    [0:QW][0:1];
  logic [SW-1:0]   den_r  [0:QW];
  sgip_pkg::side_t side_r [0:QW];
  logic [QW-1:0]   qo_r   [0:1];
  sgip_pkg::side_t sideo_r;

  logic [NW-1:0] prod   [0:1];
  logic [SW:0]   trial  [1:QW][0:1];
  logic          ge     [1:QW][0:1];
  logic [SW-1:0] rem_nxt[1:QW][0:1];
  logic          rb     [0:1];

  // ready ripples back through empty stages
  assign en[NS-1] = !v_r[NS-1] || dn_ready;
  genvar g;
  generate
    for (g = 0; g < NS - 1; g++) begin : g_en
      assign en[g] = !v_r[g] || en[g+1];
    end
  endgenerate

  assign up_ready      = en[0];
  assign dn_valid      = v_r[NS-1];
  assign dn_quot.qx    = qo_r[0];
  assign dn_quot.qy    = qo_r[1];
  assign dn_quot.side  = sideo_r;

  // dividends per axis
  always_comb begin
    prod[0] = NW'(up_opnd.cm) * NW'(up_opnd.mag_x);
    prod[1] = NW'(up_opnd.cm) * NW'(up_opnd.mag_y);
  end

  // one trial subtraction per stage and lane
  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      for (int l = 0; l < 2; l++) begin
        trial[k][l]   = {rem_r[k-1][l], low_r[k-1][l][QW-1]};
        ge[k][l]      = trial[k][l] >= {1'b0, den_r[k-1]};
        rem_nxt[k][l] = ge[k][l] ? SW'(trial[k][l] - {1'b0, den_r[k-1]})
                                 : trial[k][l][SW-1:0];
      end
    end
    for (int l = 0; l < 2; l++) begin
      rb[l] = {rem_r[QW][l], 1'b0} >= {1'b0, den_r[QW]};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // scaled dividend: top part seeds the remainder
    if (en[0]) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[0][l] <= prod[l][NW-1:CB];
        low_r[0][l] <= {prod[l][CB-1:0], {FB{1'b0}}};
        q_r[0][l]   <= '0;
      end
      den_r[0]  <= up_opnd.den;
      side_r[0] <= up_opnd.side;
    end
    // quotient bits, most significant first
    for (int k = 1; k <= QW; k++) begin
      if (en[k]) begin
        for (int l = 0; l < 2; l++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          low_r[k][l] <= low_r[k-1][l] << 1;
          q_r[k][l]   <= {q_r[k-1][l][QW-2:0], ge[k][l]};
        end
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
    // round half up on the remainder
    if (en[NS-1]) begin
      for (int l = 0; l < 2; l++) begin
        qo_r[l] <= q_r[QW][l] + QW'(rb[l]);
      end
      sideo_r <= side_r[QW];
    end
  end

endmodule

`default_nettype wire

// File: rtl/segment_intersection_point_unit.sv
// ----------------------------------------------------------------------------
// segment_intersection_point_unit
// Tests two 2D integer segments for intersection and returns a Q16.16 point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one item per pair of segments, four signed integer
//   endpoints. Taken on a rising edge with in_valid high and in_stall low.
//   Result channel (out_*): one item per input item, in order: hit,
//   collinear and degenerate flags plus the meeting point (or the middle of
//   the overlap for collinear segments) in signed Q16.16, zero on a miss.
//   The path runs through six front-end stages, one multiply stage, 32
//   quotient stages (one bit each), a rounding stage and the output register.
//   With out_stall low the bit-per-stage divider takes one item per cycle.
//   Every stage has its own valid bit and a stage moves on when the one after
//   it is empty or moving, so bubbles close up and new items keep entering
//   while a result waits at the output. in_stall rises only once every stage
//   up to the input is full behind a stalled output.
//   Reset (rst_n low, synchronous) empties the pipeline; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_point_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] in_first_start_x,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] in_first_start_y,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] in_first_end_x,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] in_first_end_y,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] in_second_start_x,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] in_second_start_y,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] in_second_end_x,
  input  logic signed [sgip_pkg::COORD_BITS-1:0] in_second_end_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_hit,
  output logic                                   out_collinear,
  output logic                                   out_degenerate,
  output logic signed [sgip_pkg::OUT_BITS-1:0]   out_point_x,
  output logic signed [sgip_pkg::OUT_BITS-1:0]   out_point_y
);

  logic            fr_ready;
  logic            op_valid;
  logic            op_ready;
  sgip_pkg::opnd_t op;
  logic            qt_valid;
  logic            qt_ready;
  sgip_pkg::quot_t qt;

  logic                          out_valid_r;
  logic                          hit_r, col_r, deg_r;
  logic [sgip_pkg::OUT_BITS-1:0] px_r, py_r;
  logic [sgip_pkg::OUT_BITS-1:0] px_nxt, py_nxt;

  sgip_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (fr_ready),
    .a_x      (in_first_start_x),
    .a_y      (in_first_start_y),
    .b_x      (in_first_end_x),
    .b_y      (in_first_end_y),
    .c_x      (in_second_start_x),
    .c_y      (in_second_start_y),
    .e_x      (in_second_end_x),
    .e_y      (in_second_end_y),
    .dn_valid (op_valid),
    .dn_ready (op_ready),
    .dn_opnd  (op)
  );

  sgip_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (op_valid),
    .up_ready (op_ready),
    .up_opnd  (op),
    .dn_valid (qt_valid),
    .dn_ready (qt_ready),
    .dn_quot  (qt)
  );

  // output register takes a new item when empty or being drained
  assign qt_ready = !out_valid_r || !out_stall;
  assign in_stall = !fr_ready;

  // place the point; zero on a miss
  always_comb begin
    px_nxt = qt.side.hit ? sgip_pkg::place(qt.side.ax, qt.qx, qt.side.neg_x) : '0;
    py_nxt = qt.side.hit ? sgip_pkg::place(qt.side.ay, qt.qy, qt.side.neg_y) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (qt_ready) begin
      out_valid_r <= qt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (qt_ready) begin
      hit_r <= qt.side.hit;
      col_r <= qt.side.col;
      deg_r <= qt.side.deg;
      px_r  <= px_nxt;
      py_r  <= py_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = hit_r;
  assign out_collinear  = col_r;
  assign out_degenerate = deg_r;
  assign out_point_x    = px_r;
  assign out_point_y    = py_r;

  // a miss always reports the origin
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_point_x == '0 && out_point_y == '0)
    else $error("miss with non-zero point");

  // degenerate excludes hit and collinear
  a_deg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> !out_hit && !out_collinear)
    else $error("degenerate item flagged as hit or collinear");

  // input only held back behind a stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with output free");

  // a stalled result is not replaced
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(px_r) && $stable(hit_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire
